@@ hdl/btcm_pkg.sv @@
// Shared types and constants for the throttle curve mapper.
`default_nettype none

package btcm_pkg;

	localparam int SAMPLE_W  = 10;
	localparam int POWER_W   = 7;
	localparam int CMD_W     = 8;
	localparam int CFG_IDX_W = 1;

	localparam logic [CFG_IDX_W-1:0] REG_MIN_POWER = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_MAX_POWER = 1'd1;

	localparam logic [POWER_W-1:0] MIN_POWER_RST = 7'd1;
	localparam logic [POWER_W-1:0] MAX_POWER_RST = 7'd127;
	localparam logic [CMD_W-1:0]   RIGHT_OFFSET  = 8'd127;

	typedef enum logic [2:0] {
		T_IDLE,
		T_LEFT,
		T_RIGHT,
		T_EMIT_L,
		T_EMIT_R
	} top_state_t;

	typedef enum logic [3:0] {
		C_IDLE,
		C_UU,
		C_KK,
		C_WA,
		C_SA,
		C_WB,
		C_SB,
		C_EST,
		C_BACK,
		C_FIX,
		C_DONE
	} curve_state_t;

	typedef struct packed {
		logic [POWER_W-1:0] min_power;
		logic [POWER_W-1:0] max_power;
	} curve_cfg_t;

	typedef struct packed {
		logic               done;
		logic [POWER_W-1:0] value;
	} curve_status_t;

endpackage

`default_nettype wire

@@ hdl/btcm_curve.sv @@
// Iterative Bezier curve evaluator: one shared multiplier, reciprocal quotient and one correction.
`default_nettype none

module btcm_curve
	import btcm_pkg::*;
#(
	parameter int CURVE_POINTS = 256
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                start,
	input  wire logic [SAMPLE_W-1:0] sample,
	input  wire curve_cfg_t          cfg,
	output curve_status_t            status
);

	localparam int D   = CURVE_POINTS - 1;
	localparam int DW  = $clog2(CURVE_POINTS);
	localparam int CW  = (DW > 8) ? DW : 8;
	localparam int SW  = 3 * DW + POWER_W;
	localparam int RW  = POWER_W + 4;
	localparam int MAW = SW;
	localparam int MBW = (DW > RW) ? DW : RW;
	localparam int PW  = MAW + MBW;
	localparam logic [SW-1:0] D3    = SW'(D * D * D);
	// floor(2^SW / D^3): estimate is exact or one short
	localparam logic [RW-1:0] RECIP = RW'((64'd1 << SW) / 64'(D3));

	curve_state_t st_q, st_d;

	logic [DW-1:0]      k_q, u_q;
	logic [2*DW-1:0]    uu_q, kk_q;
	logic [3*DW-1:0]    w_q;
	logic [SW-1:0]      acc_q;
	logic [POWER_W-1:0] quo_q;

	logic [CW-1:0]  k_ext;
	logic [DW-1:0]  k_sat;
	logic [MAW-1:0] mul_a;
	logic [MBW-1:0] mul_b;
	logic [PW-1:0]  prod;
	logic           take;
	logic           ge;

	assign take  = start && (st_q == C_IDLE || st_q == C_DONE);
	assign k_ext = CW'(sample[SAMPLE_W-1:2]);
	assign k_sat = (k_ext > CW'(D)) ? DW'(D) : DW'(k_ext);
	assign prod  = PW'(mul_a) * PW'(mul_b);
	assign ge    = (acc_q >= D3);

	always_comb begin
		st_d = st_q;
		case (st_q)
			C_IDLE:  if (take) st_d = C_UU;
			C_UU:    st_d = C_KK;
			C_KK:    st_d = C_WA;
			C_WA:    st_d = C_SA;
			C_SA:    st_d = C_WB;
			C_WB:    st_d = C_SB;
			C_SB:    st_d = C_EST;
			C_EST:   st_d = C_BACK;
			C_BACK:  st_d = C_FIX;
			C_FIX:   st_d = C_DONE;
			C_DONE:  st_d = take ? C_UU : C_IDLE;
			default: st_d = C_IDLE;
		endcase
	end

	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (st_q)
			C_UU: begin
				mul_a = MAW'(u_q);
				mul_b = MBW'(u_q);
			end
			C_KK: begin
				mul_a = MAW'(k_q);
				mul_b = MBW'(k_q);
			end
			C_WA: begin
				mul_a = MAW'(uu_q) + (MAW'(kk_q) << 1) + MAW'(kk_q);
				mul_b = MBW'(u_q);
			end
			C_SA: begin
				mul_a = MAW'(w_q);
				mul_b = MBW'(cfg.min_power);
			end
			C_WB: begin
				mul_a = MAW'(kk_q) + (MAW'(uu_q) << 1) + MAW'(uu_q);
				mul_b = MBW'(k_q);
			end
			C_SB: begin
				mul_a = MAW'(w_q);
				mul_b = MBW'(cfg.max_power);
			end
			C_EST: begin
				mul_a = acc_q;
				mul_b = MBW'(RECIP);
			end
			C_BACK: begin
				mul_a = D3;
				mul_b = MBW'(quo_q);
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= C_IDLE;
		end else begin
			st_q <= st_d;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			k_q <= k_sat;
			u_q <= DW'(D) - k_sat;
		end
		case (st_q)
			C_UU: uu_q <= prod[2*DW-1:0];
			C_KK: kk_q <= prod[2*DW-1:0];
			C_WA: w_q <= prod[3*DW-1:0];
			C_SA: acc_q <= prod[SW-1:0];
			C_WB: w_q <= prod[3*DW-1:0];
			C_SB: acc_q <= acc_q + prod[SW-1:0];
			C_EST: quo_q <= prod[SW+POWER_W-1:SW];
			C_BACK: acc_q <= acc_q - prod[SW-1:0];
			C_FIX: if (ge) quo_q <= quo_q + POWER_W'(1);
			default: ;
		endcase
	end

	assign status.done  = (st_q == C_DONE);
	assign status.value = quo_q;

endmodule

`default_nettype wire

@@ hdl/bezier_throttle_curve_mapper.sv @@
// Top level of the throttle curve mapper: handshakes, change tracking and result register.
`default_nettype none

// Each request carries a left and a right 10-bit stick sample. Each sample is cut to an
// index by dropping its two low bits and mapped through a cubic Bezier curve whose y
// control values are min_power, max_power, min_power, max_power; the value is the exact
// floor of the Bernstein sum over (CURVE_POINTS-1)^3. The last command of each side is
// kept: a changed left command is sent (tuser 0), then a changed right command plus 127
// (tuser 1); tlast marks the final command of a request, and a request that changes
// nothing sends none. One curve evaluation runs on a shared multiplier (six product
// steps, a reciprocal quotient estimate, a back-multiply and a one-step correction),
// done once per side; no new request is accepted until both commands are loaded or
// skipped, and a stall on the result side delays that. The user must write power registers
// through cfg_we only while idle; the block itself does not enforce this.

module bezier_throttle_curve_mapper
	import btcm_pkg::*;
#(
	parameter int CURVE_POINTS = 256
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 s_tvalid,
	output logic                      s_tready,
	input  wire logic [23:0]          s_tdata,  // left_sample, right_sample, zero pad
	output logic                      m_tvalid,
	input  wire logic                 m_tready,
	output logic [CMD_W-1:0]          m_tdata,  // command_byte
	output logic                      m_tuser,  // side
	output logic                      m_tlast,
	input  wire logic                 cfg_we,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [POWER_W-1:0]   cfg_data
);

	top_state_t st_q, st_d;

	curve_cfg_t    cfg_q;
	curve_status_t cv_status;

	logic [POWER_W-1:0]  left_val_q, right_val_q;
	logic [POWER_W-1:0]  last_left_q, last_right_q;
	logic [SAMPLE_W-1:0] right_sample_q;

	logic                out_valid_q;
	logic [CMD_W-1:0]    out_data_q;
	logic                out_side_q, out_last_q;

	logic                cv_start;
	logic [SAMPLE_W-1:0] cv_sample;
	logic                accept, out_free, left_chg, right_chg;
	logic                load, load_side, load_last;
	logic [CMD_W-1:0]    load_data;

	assign accept    = s_tvalid && s_tready;
	assign out_free  = !out_valid_q || m_tready;
	assign left_chg  = (left_val_q != last_left_q);
	assign right_chg = (right_val_q != last_right_q);

	btcm_curve #(
		.CURVE_POINTS(CURVE_POINTS)
	) u_curve (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cv_start),
		.sample (cv_sample),
		.cfg    (cfg_q),
		.status (cv_status)
	);

	always_comb begin
		st_d = st_q;
		case (st_q)
			T_IDLE:   if (accept) st_d = T_LEFT;
			T_LEFT:   if (cv_status.done) st_d = T_RIGHT;
			T_RIGHT:  if (cv_status.done) st_d = T_EMIT_L;
			T_EMIT_L: if (!left_chg || out_free) st_d = T_EMIT_R;
			T_EMIT_R: if (!right_chg || out_free) st_d = T_IDLE;
			default:  st_d = T_IDLE;
		endcase
	end

	always_comb begin
		s_tready  = (st_q == T_IDLE);
		cv_start  = 1'b0;
		cv_sample = s_tdata[SAMPLE_W-1:0];
		load      = 1'b0;
		load_data = CMD_W'(left_val_q);
		load_side = 1'b0;
		load_last = !right_chg;
		case (st_q)
			T_IDLE: cv_start = accept;
			T_LEFT: begin
				cv_start  = cv_status.done;
				cv_sample = right_sample_q;
			end
			T_EMIT_L: load = left_chg && out_free;
			T_EMIT_R: begin
				load      = right_chg && out_free;
				load_data = CMD_W'(right_val_q) + RIGHT_OFFSET;
				load_side = 1'b1;
				load_last = 1'b1;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q            <= T_IDLE;
			cfg_q.min_power <= MIN_POWER_RST;
			cfg_q.max_power <= MAX_POWER_RST;
			last_left_q     <= '0;
			last_right_q    <= '0;
			out_valid_q     <= 1'b0;
		end else begin
			st_q <= st_d;
			if (cfg_we) begin
				case (cfg_index)
					REG_MIN_POWER: cfg_q.min_power <= cfg_data;
					REG_MAX_POWER: cfg_q.max_power <= cfg_data;
					default: ;
				endcase
			end
			if (load && st_q == T_EMIT_L) last_left_q <= left_val_q;
			if (load && st_q == T_EMIT_R) last_right_q <= right_val_q;
			if (load) out_valid_q <= 1'b1;
			else if (m_tready) out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) right_sample_q <= s_tdata[2*SAMPLE_W-1:SAMPLE_W];
		if (st_q == T_LEFT && cv_status.done) left_val_q <= cv_status.value;
		if (st_q == T_RIGHT && cv_status.done) right_val_q <= cv_status.value;
		if (load) begin
			out_data_q <= load_data;
			out_side_q <= load_side;
			out_last_q <= load_last;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;
	assign m_tuser  = out_side_q;
	assign m_tlast  = out_last_q;

	a_right_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser |-> m_tlast)
		else $error("right command not marked last");

	a_left_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tuser |-> !m_tdata[CMD_W-1])
		else $error("left command out of range");

	a_one_request: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("request taken while busy");

	a_curve_idle_when_ready: assert property (@(posedge clk) disable iff (!arst_n)
		s_tready |-> !cv_status.done)
		else $error("curve unit finished outside a request");

endmodule

`default_nettype wire

@@ tb/tb_top.sv @@
// Self-checking testbench for the throttle curve mapper: random stick samples, curve predictor.
`default_nettype none

module tb_top
	import btcm_pkg::*;
();

	localparam int CURVE_POINTS  = 256;
	localparam int SETTLE_CYCLES = 100;
	localparam int LONG_HOLD     = 400;
	localparam int PHASE_ITEMS   = 124;

	typedef struct packed {
		logic [SAMPLE_W-1:0] left;
		logic [SAMPLE_W-1:0] right;
	} stick_pair_t;

	typedef struct packed {
		logic [CMD_W-1:0] cmd;
		logic             side;
		logic             last;
	} command_t;

	logic                 clk       = 1'b0;
	logic                 arst_n    = 1'b0;
	logic                 s_tvalid  = 1'b0;
	logic                 s_tready;
	logic [23:0]          s_tdata   = '0;  // left_sample, right_sample, zero pad
	logic                 m_tvalid;
	logic                 m_tready  = 1'b0;
	logic [CMD_W-1:0]     m_tdata;         // command_byte
	logic                 m_tuser;         // side
	logic                 m_tlast;
	logic                 cfg_we    = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [POWER_W-1:0]   cfg_data  = '0;

	stick_pair_t   pending_requests[$];
	command_t      expected_commands[$];
	logic [POWER_W-1:0] lo_pwr = MIN_POWER_RST;
	logic [POWER_W-1:0] hi_pwr = MAX_POWER_RST;
	logic [POWER_W-1:0] left_cmd_seen  = '0;
	logic [POWER_W-1:0] right_cmd_seen = '0;
	logic          idle_on    = 1'b1;
	logic          long_hold  = 1'b0;
	int            send_gap   = 0;
	int            ready_gap  = 0;
	int            accepted   = 0;
	int            errors     = 0;

	bezier_throttle_curve_mapper #(
		.CURVE_POINTS(CURVE_POINTS)
	) i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic logic [POWER_W-1:0] curve_level(input logic [SAMPLE_W-1:0] sample);
		longint unsigned span, k, u, s;
		span = 64'(CURVE_POINTS - 1);
		k = 64'(sample >> 2);
		if (k > span)
			k = span;
		u = span - k;
		s = u * u * u * lo_pwr + 3 * k * u * u * hi_pwr
		  + 3 * k * k * u * lo_pwr + k * k * k * hi_pwr;
		return POWER_W'(s / (span * span * span));
	endfunction

	function automatic void track_commands(input logic [23:0] data);
		logic [POWER_W-1:0] lv, rv;
		logic               l_chg, r_chg;
		lv = curve_level(data[SAMPLE_W-1:0]);
		rv = curve_level(data[2*SAMPLE_W-1:SAMPLE_W]);
		l_chg = (lv != left_cmd_seen);
		r_chg = (rv != right_cmd_seen);
		if (l_chg) begin
			expected_commands.push_back('{cmd: CMD_W'(lv), side: 1'b0, last: !r_chg});
			left_cmd_seen = lv;
		end
		if (r_chg) begin
			expected_commands.push_back('{cmd: CMD_W'(rv) + RIGHT_OFFSET, side: 1'b1,
				last: 1'b1});
			right_cmd_seen = rv;
		end
	endfunction

	// request driver
	always @(posedge clk) begin
		if (arst_n) begin
			if (s_tvalid && s_tready) begin
				track_commands(s_tdata);
				accepted <= accepted + 1;
			end
			if (!s_tvalid || s_tready) begin
				if (send_gap > 0) begin
					send_gap <= send_gap - 1;
					s_tvalid <= 1'b0;
				end else if (idle_on && $urandom_range(0, 5) == 0) begin
					send_gap <= $urandom_range(0, 12);
					s_tvalid <= 1'b0;
				end else if (pending_requests.size() != 0) begin
					stick_pair_t p;
					p = pending_requests.pop_front();
					s_tdata  <= {4'b0, p.right, p.left};
					s_tvalid <= 1'b1;
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// result monitor
	always @(posedge clk) begin
		if (arst_n) begin
			if (m_tvalid && m_tready) begin
				command_t got, want;
				got = '{cmd: m_tdata, side: m_tuser, last: m_tlast};
				if (expected_commands.size() == 0) begin
					errors = errors + 1;
					if (errors <= 10)
						$display("unexpected command: cmd=%0d side=%0d last=%0d",
							got.cmd, got.side, got.last);
				end else begin
					want = expected_commands.pop_front();
					if (got != want) begin
						errors = errors + 1;
						if (errors <= 10)
							$display({"mismatch: exp cmd=%0d side=%0d last=%0d,",
								" got cmd=%0d side=%0d last=%0d"},
								want.cmd, want.side, want.last,
								got.cmd, got.side, got.last);
					end
				end
			end
			if (long_hold) begin
				m_tready <= 1'b0;
			end else if (ready_gap > 0) begin
				ready_gap <= ready_gap - 1;
				m_tready  <= 1'b0;
			end else if (idle_on && $urandom_range(0, 5) == 0) begin
				ready_gap <= $urandom_range(0, 12);
				m_tready  <= 1'b0;
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	// long receiver hold-off while requests keep coming
	initial begin
		while (accepted < 180)
			@(posedge clk);
		long_hold <= 1'b1;
		repeat (LONG_HOLD) @(posedge clk);
		long_hold <= 1'b0;
	end

	initial begin
		#5000000;
		$display("Test completed with failures");
		$finish;
	end

	task automatic write_power(input logic [CFG_IDX_W-1:0] idx, input logic [POWER_W-1:0] val);
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx == REG_MIN_POWER)
			lo_pwr = val;
		else if (idx == REG_MAX_POWER)
			hi_pwr = val;
	endtask

	// sampled on the falling edge so the driver's updates have settled
	task automatic wait_drained();
		while (pending_requests.size() != 0 || s_tvalid || expected_commands.size() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	function automatic stick_pair_t next_pair(input stick_pair_t prev);
		stick_pair_t p;
		int          d;
		p.left  = SAMPLE_W'($urandom_range(0, 1023));
		p.right = SAMPLE_W'($urandom_range(0, 1023));
		case ($urandom_range(0, 7))
			0: p = prev;
			1: begin
				p.left  = {prev.left[9:2], p.left[1:0]};
				p.right = {prev.right[9:2], p.right[1:0]};
			end
			2: begin
				p.left  = $urandom_range(0, 1) ? 10'd1023 : 10'd0;
				p.right = $urandom_range(0, 1) ? 10'd1023 : 10'd0;
			end
			3: begin
				d = int'(prev.left) + $urandom_range(0, 16) - 8;
				p.left = (d < 0) ? 10'd0 : (d > 1023) ? 10'd1023 : SAMPLE_W'(d);
			end
			default: ;
		endcase
		return p;
	endfunction

	task automatic run_phase(input logic [POWER_W-1:0] lo, input logic [POWER_W-1:0] hi);
		stick_pair_t p;
		write_power(REG_MIN_POWER, lo);
		write_power(REG_MAX_POWER, hi);
		pending_requests.push_back('{left: 10'd0, right: 10'd1023});
		pending_requests.push_back('{left: 10'd1023, right: 10'd0});
		p = '{left: 10'd512, right: 10'd512};
		repeat (PHASE_ITEMS) begin
			p = next_pair(p);
			pending_requests.push_back(p);
		end
		wait_drained();
	endtask

	initial begin
		stick_pair_t directed[$];
		directed = '{
			'{left: 10'd0,    right: 10'd0},
			'{left: 10'd0,    right: 10'd0},
			'{left: 10'd3,    right: 10'd2},
			'{left: 10'd1023, right: 10'd1023},
			'{left: 10'd1020, right: 10'd1023},
			'{left: 10'd4,    right: 10'd1020},
			'{left: 10'd1020, right: 10'd4},
			'{left: 10'd512,  right: 10'd511},
			'{left: 10'd511,  right: 10'd512},
			'{left: 10'd0,    right: 10'd1023},
			'{left: 10'd1023, right: 10'd0},
			'{left: 10'd8,    right: 10'd1016},
			'{left: 10'd256,  right: 10'd768},
			'{left: 10'd682,  right: 10'd341},
			'{left: 10'd1023, right: 10'd1023}
		};
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);
		foreach (directed[i])
			pending_requests.push_back(directed[i]);
		wait_drained();
		run_phase(MIN_POWER_RST, MAX_POWER_RST);
		run_phase(7'd0, 7'd127);
		run_phase(7'd127, 7'd0);
		run_phase(7'd0, 7'd0);
		run_phase(7'd127, 7'd127);
		run_phase(POWER_W'($urandom_range(0, 127)), POWER_W'($urandom_range(0, 127)));
		@(posedge clk);
		idle_on <= 1'b0;
		run_phase(POWER_W'($urandom_range(0, 127)), POWER_W'($urandom_range(0, 127)));
		if (errors == 0 && expected_commands.size() == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule

`default_nettype wire

@@ files.f @@
hdl/btcm_pkg.sv
hdl/btcm_curve.sv
hdl/bezier_throttle_curve_mapper.sv
tb/tb_top.sv
